/* hw/rtl/rcd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types and constants for the RC-decay line sensor timer.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int SENSOR_COUNT_DEF = 5;
    localparam int PHASE_BITS_DEF   = 8;

    // Fixed widths of the item fields.
    localparam int OUT_TIMES  = 5;
    localparam int TIME_OUT_W = 8;
    localparam int ELAPSED_W  = 32;
    localparam int DIV_W      = 8;

    localparam logic [DIV_W-1:0] TPC_RESET = 8'd100;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef struct packed {
        logic [OUT_TIMES-1:0][TIME_OUT_W-1:0] times;
        logic [ELAPSED_W-1:0]                 elapsed;
        logic                                 charge_drive;
        logic                                 frame_done;
    } t_result;

endpackage

/* hw/rtl/rc_decay_line_sensor_timer_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_decay_line_sensor_timer_top
// RC-decay reflectance sensor timer with a tick-divided stopwatch.
// ----------------------------------------------------------------------------
// Each item is either one timer tick carrying the sensor line levels or a
// stopwatch start. Every item yields exactly one result. The result is
// offered in the cycle after the item is accepted when the output register
// is free, and later when the output is stalled. A new item is taken every
// cycle while the input is not stalled: the whole update is a single
// compare-and-increment pass between the state registers and the result
// register. A two-entry output buffer keeps the input open while one result
// waits; the input stalls only when both entries are full.
// ticks_per_count may be written only while no item is in flight.
module rc_decay_line_sensor_timer_top import rcd_pkg::*; #(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_op,
    input  logic [OUT_TIMES-1:0] i_sensor_levels,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [7:0]           o_time_0,
    output logic [7:0]           o_time_1,
    output logic [7:0]           o_time_2,
    output logic [7:0]           o_time_3,
    output logic [7:0]           o_time_4,
    output logic [31:0]          o_elapsed,
    output logic                 o_charge_drive,
    output logic                 o_frame_done
);

    logic    w_accept;
    logic    w_take;
    t_result w_result;
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;
    assign w_take     = r_out_valid && !i_out_stall;

    rcd_core #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .PHASE_BITS   (PHASE_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_accept        (w_accept),
        .i_op            (i_op),
        .i_sensor_levels (i_sensor_levels),
        .o_result        (w_result)
    );

    always_comb begin
        n_out        = r_out;
        n_out_valid  = r_out_valid;
        n_skid       = r_skid;
        n_skid_valid = r_skid_valid;
        if (w_take || !r_out_valid) begin
            // The skid entry is older than anything arriving now.
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (w_accept) begin
                n_out       = w_result;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (w_accept) begin
            n_skid       = w_result;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_time_0       = r_out.times[0];
    assign o_time_1       = r_out.times[1];
    assign o_time_2       = r_out.times[2];
    assign o_time_3       = r_out.times[3];
    assign o_time_4       = r_out.times[4];
    assign o_elapsed      = r_out.elapsed;
    assign o_charge_drive = r_out.charge_drive;
    assign o_frame_done   = r_out.frame_done;

endmodule

/* hw/rtl/rcd_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_core
// Phase counter, per-sensor decay time capture and the stopwatch divider.
// Produces the result of the item presented this cycle.
// ----------------------------------------------------------------------------
module rcd_core import rcd_pkg::*; #(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int PHASE_BITS   = PHASE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    input  logic                 i_accept,
    input  logic                 i_op,
    input  logic [OUT_TIMES-1:0] i_sensor_levels,
    output t_result              o_result
);

    // Only sensors that have a level bit on the input can ever record a time.
    localparam int LANES = (SENSOR_COUNT < OUT_TIMES) ? SENSOR_COUNT : OUT_TIMES;
    localparam int TW    = (PHASE_BITS < TIME_OUT_W) ? PHASE_BITS : TIME_OUT_W;

    logic [PHASE_BITS-1:0] r_phase, n_phase;
    logic [TW-1:0]         r_work  [LANES];
    logic [TW-1:0]         n_work  [LANES];
    logic [TW-1:0]         r_latch [LANES];
    logic [TW-1:0]         n_latch [LANES];
    logic [DIV_W-1:0]      r_div, n_div;
    logic [DIV_W-1:0]      r_tpc;
    logic [ELAPSED_W-1:0]  r_elapsed, n_elapsed;
    logic                  r_charge, n_charge;
    logic                  n_done;
    logic [DIV_W-1:0]      w_div_inc;
    logic [OUT_TIMES-1:0][TIME_OUT_W-1:0] w_times;

    assign w_div_inc = r_div + DIV_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_work    = r_work;
        n_latch   = r_latch;
        n_div     = r_div;
        n_elapsed = r_elapsed;
        n_charge  = r_charge;
        n_done    = 1'b0;
        if (t_op'(i_op) == OP_START) begin
            n_div     = '0;
            n_elapsed = '0;
        end else begin
            if (w_div_inc >= r_tpc) begin
                n_elapsed = r_elapsed + ELAPSED_W'(1);
                n_div     = '0;
            end else begin
                n_div = w_div_inc;
            end
            if (r_phase == '0) begin
                for (int i = 0; i < LANES; i++) begin
                    n_latch[i] = r_work[i];
                    n_work[i]  = '0;
                end
                n_charge = 1'b1;
                n_done   = 1'b1;
            end else if (r_phase == PHASE_BITS'(1)) begin
                n_charge = 1'b0;
            end else begin
                for (int i = 0; i < LANES; i++) begin
                    if (i_sensor_levels[i]) begin
                        n_work[i] = r_phase[TW-1:0];
                    end
                end
            end
            n_phase = r_phase + PHASE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_div     <= '0;
            r_elapsed <= '0;
            r_charge  <= 1'b0;
            r_tpc     <= TPC_RESET;
            for (int i = 0; i < LANES; i++) begin
                r_work[i]  <= '0;
                r_latch[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_tpc <= i_cfg_wdata;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_div     <= n_div;
                r_elapsed <= n_elapsed;
                r_charge  <= n_charge;
                r_work    <= n_work;
                r_latch   <= n_latch;
            end
        end
    end

    // Sensors beyond the configured count report zero.
    for (genvar g = 0; g < OUT_TIMES; g++) begin : g_times
        if (g < LANES) begin : g_live
            assign w_times[g] = TIME_OUT_W'(n_latch[g]);
        end else begin : g_absent
            assign w_times[g] = '0;
        end
    end

    always_comb begin
        o_result.times        = w_times;
        o_result.elapsed      = n_elapsed;
        o_result.charge_drive = n_charge;
        o_result.frame_done   = n_done;
    end

endmodule

/* tb/rcd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcd_checker
// Watches the item channels and the configuration port of the RC-decay
// sensor timer, keeps its own model of the phase counter, decay times and
// stopwatch, and compares every accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module rcd_checker import rcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [DIV_W-1:0]     i_cfg_wdata,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic                 i_op,
    input  logic [OUT_TIMES-1:0] i_sensor_levels,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [7:0]           i_time_0,
    input  logic [7:0]           i_time_1,
    input  logic [7:0]           i_time_2,
    input  logic [7:0]           i_time_3,
    input  logic [7:0]           i_time_4,
    input  logic [31:0]          i_elapsed,
    input  logic                 i_charge_drive,
    input  logic                 i_frame_done,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [7:0]           phase_q;
    logic [7:0]           work_times[OUT_TIMES];
    logic [7:0]           frame_times[OUT_TIMES];
    logic [DIV_W-1:0]     tick_div_q;
    logic [ELAPSED_W-1:0] elapsed_q;
    logic                 charge_q;
    logic [DIV_W-1:0]     ticks_per_count_q;

    t_result expected_readings[$];
    int      mismatches = 0;

    // Advances the model by one item and returns the reading it should produce.
    function automatic t_result step_decay_timer(t_op op, logic [OUT_TIMES-1:0] levels);
        t_result r;
        logic    latched;
        latched = 1'b0;
        if (op == OP_START) begin
            elapsed_q  = '0;
            tick_div_q = '0;
        end else begin
            tick_div_q = tick_div_q + 1'b1;
            // A divisor of zero lets every tick through.
            if (tick_div_q >= ticks_per_count_q) begin
                elapsed_q  = elapsed_q + 1'b1;
                tick_div_q = '0;
            end
            if (phase_q == 8'd0) begin
                for (int k = 0; k < OUT_TIMES; k++) begin
                    frame_times[k] = work_times[k];
                    work_times[k]  = '0;
                end
                charge_q = 1'b1;
                latched  = 1'b1;
            end else if (phase_q == 8'd1) begin
                charge_q = 1'b0;
            end else begin
                for (int k = 0; k < OUT_TIMES; k++) begin
                    if (levels[k]) begin
                        work_times[k] = phase_q;
                    end
                end
            end
            phase_q = phase_q + 1'b1;
        end
        for (int k = 0; k < OUT_TIMES; k++) begin
            r.times[k] = frame_times[k];
        end
        r.elapsed      = elapsed_q;
        r.charge_drive = charge_q;
        r.frame_done   = latched;
        return r;
    endfunction

    function automatic void report_mismatch(string field, longint unsigned want,
                                            longint unsigned got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        logic [7:0] got_times[OUT_TIMES];
        if (!i_rst_n) begin
            phase_q           = '0;
            tick_div_q        = '0;
            elapsed_q         = '0;
            charge_q          = 1'b0;
            ticks_per_count_q = TPC_RESET;
            for (int k = 0; k < OUT_TIMES; k++) begin
                work_times[k]  = '0;
                frame_times[k] = '0;
            end
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                ticks_per_count_q = i_cfg_wdata;
            end
            if (i_in_valid && !i_in_stall) begin
                expected_readings.push_back(step_decay_timer(t_op'(i_op), i_sensor_levels));
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("unexpected result", 0, 1);
                end else begin
                    want = expected_readings.pop_front();
                    got_times[0] = i_time_0;
                    got_times[1] = i_time_1;
                    got_times[2] = i_time_2;
                    got_times[3] = i_time_3;
                    got_times[4] = i_time_4;
                    for (int k = 0; k < OUT_TIMES; k++) begin
                        if (got_times[k] !== want.times[k]) begin
                            report_mismatch($sformatf("time_%0d", k), want.times[k],
                                            got_times[k]);
                        end
                    end
                    if (i_elapsed !== want.elapsed) begin
                        report_mismatch("elapsed", want.elapsed, i_elapsed);
                    end
                    if (i_charge_drive !== want.charge_drive) begin
                        report_mismatch("charge_drive", want.charge_drive, i_charge_drive);
                    end
                    if (i_frame_done !== want.frame_done) begin
                        report_mismatch("frame_done", want.frame_done, i_frame_done);
                    end
                end
            end
        end
        o_pending    <= expected_readings.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the RC-decay line sensor timer: directed ticks and
// stopwatch starts around the divisor corner cases, then random frames whose
// sensor lines decay at random phases, under three idling patterns.
// ----------------------------------------------------------------------------
module tb;
    import rcd_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [DIV_W-1:0]     cfg_wdata = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_TICK;
    logic [OUT_TIMES-1:0] sensor_levels = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           time_0, time_1, time_2, time_3, time_4;
    logic [31:0]          elapsed;
    logic                 charge_drive;
    logic                 frame_done;
    int                   fail_count;
    int                   pending;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int frame_phase = 0;
    int decay_at[OUT_TIMES];

    always #5 clk = ~clk;

    rc_decay_line_sensor_timer_top u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (op),
        .i_sensor_levels (sensor_levels),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_time_0        (time_0),
        .o_time_1        (time_1),
        .o_time_2        (time_2),
        .o_time_3        (time_3),
        .o_time_4        (time_4),
        .o_elapsed       (elapsed),
        .o_charge_drive  (charge_drive),
        .o_frame_done    (frame_done)
    );

    rcd_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_in_valid      (in_valid),
        .i_in_stall      (in_stall),
        .i_op            (op),
        .i_sensor_levels (sensor_levels),
        .i_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .i_time_0        (time_0),
        .i_time_1        (time_1),
        .i_time_2        (time_2),
        .i_time_3        (time_3),
        .i_time_4        (time_4),
        .i_elapsed       (elapsed),
        .i_charge_drive  (charge_drive),
        .i_frame_done    (frame_done),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always @(posedge clk) begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic put_item(t_op item_op, logic [OUT_TIMES-1:0] levels);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        op            <= item_op;
        sensor_levels <= levels;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic send_tick(logic [OUT_TIMES-1:0] levels);
        put_item(OP_TICK, levels);
        frame_phase = (frame_phase + 1) % 256;
    endtask

    // Stops the sender and waits until every reading has come back.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic write_ticks_per_count(logic [DIV_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly well-formed frames: each line reads high until its own decay
    // phase. The rest are stopwatch starts and ticks with arbitrary levels.
    task automatic run_random_frames(int count);
        int                   pick;
        logic [OUT_TIMES-1:0] levels;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                put_item(OP_START, OUT_TIMES'($urandom_range(31)));
            end else if (pick < 15) begin
                send_tick(OUT_TIMES'($urandom_range(31)));
            end else begin
                if (frame_phase == 0) begin
                    for (int k = 0; k < OUT_TIMES; k++) begin
                        decay_at[k] = $urandom_range(256);
                    end
                end
                for (int k = 0; k < OUT_TIMES; k++) begin
                    levels[k] = (frame_phase < decay_at[k]);
                end
                send_tick(levels);
            end
        end
    endtask

    initial begin
        for (int k = 0; k < OUT_TIMES; k++) begin
            decay_at[k] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Start right out of reset, the frame latch at phase zero, the drive
        // release at phase one, then single lines and mixes.
        put_item(OP_START, 5'h1F);
        send_tick(5'h00);
        send_tick(5'h1F);
        send_tick(5'h1F);
        send_tick(5'h01);
        send_tick(5'h02);
        send_tick(5'h04);
        send_tick(5'h08);
        send_tick(5'h10);
        send_tick(5'h15);
        send_tick(5'h0A);

        // A zero divisor counts every tick.
        wait_drained();
        write_ticks_per_count(8'd0);
        repeat (3) send_tick(5'h1F);
        put_item(OP_START, 5'h00);
        repeat (2) send_tick(5'h0A);

        // Let the divider climb, then lower the divisor below it.
        wait_drained();
        write_ticks_per_count(8'd255);
        repeat (6) send_tick(OUT_TIMES'($urandom_range(31)));
        wait_drained();
        write_ticks_per_count(8'd3);
        repeat (3) send_tick(OUT_TIMES'($urandom_range(31)));

        wait_drained();
        write_ticks_per_count(8'd1);
        send_idle_pct = 12;
        recv_idle_pct = 85;
        run_random_frames(200);

        wait_drained();
        write_ticks_per_count(8'd255);
        send_idle_pct = 85;
        recv_idle_pct = 12;
        run_random_frames(200);

        wait_drained();
        write_ticks_per_count(DIV_W'($urandom_range(2, 254)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_frames(200);

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
